// ===== design/vwae_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel window extract package
// Register indexes, reset values, field widths and the result type.
// ----------------------------------------------------------------------------
package vwae_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int EXT_REG_W  = 11;
	localparam int CRD_REG_W  = 10;
	localparam int VOXEL_W    = 8;
	localparam int LOCAL_W    = 10;
	localparam int ID_W       = 30;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [EXT_REG_W-1:0]  ext_reg_t;
	typedef logic [CRD_REG_W-1:0]  crd_reg_t;
	typedef logic [VOXEL_W-1:0]    voxel_t;
	typedef logic [LOCAL_W-1:0]    local_t;
	typedef logic [ID_W-1:0]       id_t;

	// Register map
	localparam cfg_idx_t REG_VOL_WIDTH     = 3'd0;
	localparam cfg_idx_t REG_VOL_HEIGHT    = 3'd1;
	localparam cfg_idx_t REG_VOL_DEPTH     = 3'd2;
	localparam cfg_idx_t REG_CENTER_X      = 3'd3;
	localparam cfg_idx_t REG_CENTER_Y      = 3'd4;
	localparam cfg_idx_t REG_START_Z       = 3'd5;
	localparam cfg_idx_t REG_WINDOW_LENGTH = 3'd6;
	localparam cfg_idx_t REG_WINDOW_HEIGHT = 3'd7;

	// Reset values
	localparam ext_reg_t RST_VOL_EXTENT    = 11'd1024;
	localparam crd_reg_t RST_CENTER        = 10'd512;
	localparam crd_reg_t RST_START_Z       = 10'd0;
	localparam ext_reg_t RST_WINDOW_EXTENT = 11'd1024;

	// Value of an active voxel
	localparam voxel_t VOXEL_ACTIVE = 8'd1;

	typedef struct packed {
		local_t lz;
		local_t ly;
		local_t lx;
		id_t    id;
		logic   err;
	} result_t;

endpackage : vwae_pkg

// ===== design/voxel_window_active_extract.sv =====
// ----------------------------------------------------------------------------
// Voxel window active extract
// Streams voxel bytes of a volume in raster order (x fastest, then y, then z)
// and reports every active voxel (byte equal to one) inside a cropped window.
// Usage: the voxel channel takes one byte per transaction. The result of a
// transaction is registered into the result register, or into the skid
// register when that is full; one voxel is taken in every cycle while the
// result side keeps up. Results leave through a two-entry output stage
// (result register and skid register), so voxel_ready is a registered signal
// and drops only when both entries are full; a stalled receiver therefore
// stops the voxel stream two results late. A window that does not fit the
// volume gives one error result at the first voxel of the volume, or the
// first after it goes bad, and nothing more until the volume ends. Registers
// are written through cfg_we/cfg_index/cfg_data and take effect at once;
// write them only while the block is idle. Reset loads the register reset
// values, sets the position to the origin and empties the output stage.
// ----------------------------------------------------------------------------
module voxel_window_active_extract #(
	parameter int MAX_DIM = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  vwae_pkg::cfg_idx_t  cfg_index,
	input  vwae_pkg::cfg_data_t cfg_data,
	input  logic                voxel_valid,
	output logic                voxel_ready,
	input  vwae_pkg::voxel_t    voxel_value,
	output logic                result_valid,
	input  logic                result_ready,
	output vwae_pkg::local_t    local_z,
	output vwae_pkg::local_t    local_y,
	output vwae_pkg::local_t    local_x,
	output vwae_pkg::id_t       active_id,
	output logic                window_error
);
	import vwae_pkg::*;

	// Width of a clamped extent, of the position counters, and of the sums
	// used in the window compares.
	localparam int MD_W  = $clog2(MAX_DIM + 1);
	localparam int EXT_W = (MD_W > EXT_REG_W) ? MD_W : EXT_REG_W;
	localparam int POS_W = $clog2(MAX_DIM);
	localparam int CMP_W = EXT_W + 1;

	typedef logic [CMP_W-1:0] cmp_t;

	// Configuration registers
	ext_reg_t vol_width_q, vol_height_q, vol_depth_q;
	crd_reg_t center_x_q, center_y_q, start_z_q;
	ext_reg_t window_length_q, window_height_q;

	// Stream state
	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	id_t              id_count_q;
	logic             error_sent_q;

	// Output stage: result register and skid register
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q     <= RST_VOL_EXTENT;
			vol_height_q    <= RST_VOL_EXTENT;
			vol_depth_q     <= RST_VOL_EXTENT;
			center_x_q      <= RST_CENTER;
			center_y_q      <= RST_CENTER;
			start_z_q       <= RST_START_Z;
			window_length_q <= RST_WINDOW_EXTENT;
			window_height_q <= RST_WINDOW_EXTENT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOL_WIDTH:     vol_width_q     <= cfg_data;
				REG_VOL_HEIGHT:    vol_height_q    <= cfg_data;
				REG_VOL_DEPTH:     vol_depth_q     <= cfg_data;
				REG_CENTER_X:      center_x_q      <= cfg_data[CRD_REG_W-1:0];
				REG_CENTER_Y:      center_y_q      <= cfg_data[CRD_REG_W-1:0];
				REG_START_Z:       start_z_q       <= cfg_data[CRD_REG_W-1:0];
				REG_WINDOW_LENGTH: window_length_q <= cfg_data;
				REG_WINDOW_HEIGHT: window_height_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Extents above MAX_DIM count as MAX_DIM.
	logic [EXT_W-1:0] ext_w, ext_h, ext_d;
	assign ext_w = (EXT_W'(vol_width_q) > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM)
		: EXT_W'(vol_width_q);
	assign ext_h = (EXT_W'(vol_height_q) > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM)
		: EXT_W'(vol_height_q);
	assign ext_d = (EXT_W'(vol_depth_q) > EXT_W'(MAX_DIM)) ? EXT_W'(MAX_DIM)
		: EXT_W'(vol_depth_q);

	// Window placement. The start along x and y is the centre less half the
	// side, floored at zero; a centre below the half side is an error anyway.
	crd_reg_t half_len, xs, ys;
	logic     window_bad;
	cmp_t     x_end, y_end, z_end;

	assign half_len = window_length_q[EXT_REG_W-1:1];
	assign xs = (center_x_q >= half_len) ? center_x_q - half_len : '0;
	assign ys = (center_y_q >= half_len) ? center_y_q - half_len : '0;
	assign x_end = CMP_W'(xs) + CMP_W'(window_length_q);
	assign y_end = CMP_W'(ys) + CMP_W'(window_length_q);
	assign z_end = CMP_W'(start_z_q) + CMP_W'(window_height_q);

	assign window_bad = (window_length_q == '0) || (window_height_q == '0)
		|| (center_x_q < half_len) || (center_y_q < half_len)
		|| (x_end > CMP_W'(ext_w)) || (y_end > CMP_W'(ext_h))
		|| (z_end > CMP_W'(ext_d));

	// Membership of the current position in the window
	cmp_t px, py, pz;
	logic in_window, emit_active, emit_error, emit;

	assign px = CMP_W'(pos_x_q);
	assign py = CMP_W'(pos_y_q);
	assign pz = CMP_W'(pos_z_q);

	assign in_window = (px >= CMP_W'(xs)) && (px < x_end)
		&& (py >= CMP_W'(ys)) && (py < y_end)
		&& (pz >= CMP_W'(start_z_q)) && (pz < z_end);

	assign emit_error  = window_bad && !error_sent_q;
	assign emit_active = !window_bad && !error_sent_q && in_window
		&& (voxel_value == VOXEL_ACTIVE);
	assign emit = emit_error || emit_active;

	// Result of the present voxel
	cmp_t    dz, dy, dx;
	result_t res;

	assign dz = pz - CMP_W'(start_z_q);
	assign dy = py - CMP_W'(ys);
	assign dx = px - CMP_W'(xs);

	always_comb begin
		if (emit_error) begin
			res = '0;
			res.err = 1'b1;
		end else begin
			res.lz  = dz[LOCAL_W-1:0];
			res.ly  = dy[LOCAL_W-1:0];
			res.lx  = dx[LOCAL_W-1:0];
			res.id  = id_count_q;
			res.err = 1'b0;
		end
	end

	// Raster position step; a zero extent behaves as an extent of one.
	logic x_wrap, y_wrap, z_wrap;

	assign x_wrap = !((px + CMP_W'(1)) < CMP_W'(ext_w));
	assign y_wrap = !((py + CMP_W'(1)) < CMP_W'(ext_h));
	assign z_wrap = !((pz + CMP_W'(1)) < CMP_W'(ext_d));

	logic voxel_take;
	assign voxel_take = voxel_valid && voxel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
			id_count_q   <= '0;
			error_sent_q <= 1'b0;
		end else if (voxel_take) begin
			if (!x_wrap) begin
				pos_x_q <= pos_x_q + POS_W'(1);
			end else begin
				pos_x_q <= '0;
				if (!y_wrap) begin
					pos_y_q <= pos_y_q + POS_W'(1);
				end else begin
					pos_y_q <= '0;
					pos_z_q <= z_wrap ? '0 : pos_z_q + POS_W'(1);
				end
			end
			// The end of the volume clears the id and the error mark.
			if (x_wrap && y_wrap && z_wrap) begin
				id_count_q   <= '0;
				error_sent_q <= 1'b0;
			end else begin
				if (emit_active) begin
					id_count_q <= id_count_q + ID_W'(1);
				end
				if (emit_error) begin
					error_sent_q <= 1'b1;
				end
			end
		end
	end

	// Output stage. A new result goes to the result register when that is
	// empty or being emptied, otherwise to the skid register. The skid entry
	// moves up as soon as the result register is taken.
	logic out_take, load_new;
	assign out_take = out_valid_q && result_ready;
	assign load_new = voxel_take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (load_new) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (load_new) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign voxel_ready  = !skid_valid_q;
	assign result_valid = out_valid_q;
	assign local_z      = out_q.lz;
	assign local_y      = out_q.ly;
	assign local_x      = out_q.lx;
	assign active_id    = out_q.id;
	assign window_error = out_q.err;

`ifndef SYNTHESIS
	// The skid register never holds a result ahead of an empty result register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while result register empty");

	// The skid register fills only when the receiver stalled a waiting result.
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !result_ready))
		else $error("skid entry filled without a stalled result");

	// An error result carries no position and no id.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && window_error) |->
			(local_z == '0 && local_y == '0 && local_x == '0 && active_id == '0))
		else $error("error result with non-zero payload");
`endif

endmodule : voxel_window_active_extract

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel window active extract testbench
// Streams voxel bytes into the block and predicts every result in step with
// it. Each phase sets the volume extents and the crop window, lines the scan
// up with a volume start when near and sends bytes, with either, both or no
// side idling at random. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

	import vwae_pkg::*;

	localparam int          MAX_DIM       = 1024;
	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int unsigned ALIGN_MAX     = 200;
	localparam int unsigned RANDOM_ITEMS  = 1750;
	localparam int unsigned PHASE_ITEMS   = 150;
	localparam int          LONG_HOLD     = 300;
	localparam int          REPORT_LIMIT  = 100;

	// Idling per phase: none, sender only, receiver only, both.
	localparam int unsigned TX_IDLE  [4] = '{0, 53, 0, 38};
	localparam int unsigned RX_STALL [4] = '{0, 0, 53, 38};

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      cfg_we       = 1'b0;
	cfg_idx_t  cfg_index    = REG_VOL_WIDTH;
	cfg_data_t cfg_data     = '0;
	logic      voxel_valid  = 1'b0;
	logic      voxel_ready;
	voxel_t    voxel_value  = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	local_t    local_z;
	local_t    local_y;
	local_t    local_x;
	id_t       active_id;
	logic      window_error;

	// Bytes waiting to be offered; the front one is on the bus while valid is high.
	voxel_t  voxel_backlog[$];
	// Results the block still owes us, oldest first.
	result_t active_hits[$];

	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int          hold_req     = 0;
	int          hold_seen    = 0;
	int          hold_left    = 0;
	int          cycles       = 0;
	int          mismatches   = 0;

	// Shadow copy of the register file, at the block's own widths.
	ext_reg_t ext_w    = RST_VOL_EXTENT;
	ext_reg_t ext_h    = RST_VOL_EXTENT;
	ext_reg_t ext_d    = RST_VOL_EXTENT;
	crd_reg_t ctr_x    = RST_CENTER;
	crd_reg_t ctr_y    = RST_CENTER;
	crd_reg_t z_first  = RST_START_Z;
	ext_reg_t side_len = RST_WINDOW_EXTENT;
	ext_reg_t layers   = RST_WINDOW_EXTENT;

	// Shadow scan state: current position, next id and whether this volume
	// has already had its error result.
	int unsigned scan_x      = 0;
	int unsigned scan_y      = 0;
	int unsigned scan_z      = 0;
	id_t         next_id     = '0;
	bit          error_given = 1'b0;

	voxel_window_active_extract #(
		.MAX_DIM(MAX_DIM)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.voxel_valid (voxel_valid),
		.voxel_ready (voxel_ready),
		.voxel_value (voxel_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.local_z     (local_z),
		.local_y     (local_y),
		.local_x     (local_x),
		.active_id   (active_id),
		.window_error(window_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Extents beyond the largest supported volume behave as the largest one.
	function automatic int unsigned extent(ext_reg_t e);
		return (int'(e) > MAX_DIM) ? MAX_DIM : int'(e);
	endfunction

	// Moves a scan position on by one voxel in raster order. Returns one when
	// the position wraps back to the origin, which is the end of a volume. A
	// zero extent behaves as an extent of one here.
	function automatic bit step_scan(inout int unsigned x, inout int unsigned y,
			inout int unsigned z);
		if (x + 1 < extent(ext_w)) begin
			x++;
			return 1'b0;
		end
		x = 0;
		if (y + 1 < extent(ext_h)) begin
			y++;
			return 1'b0;
		end
		y = 0;
		if (z + 1 < extent(ext_d)) begin
			z++;
			return 1'b0;
		end
		z = 0;
		return 1'b1;
	endfunction

	// The window is unusable when it is empty, when a centre sits closer to
	// zero than half the side, or when it runs past the volume on any axis.
	function automatic bit window_fault(int unsigned xs, int unsigned ys);
		int unsigned half = int'(side_len) / 2;
		if (side_len == '0 || layers == '0)
			return 1'b1;
		if (int'(ctr_x) < half || int'(ctr_y) < half)
			return 1'b1;
		if (xs + int'(side_len) > extent(ext_w))
			return 1'b1;
		if (ys + int'(side_len) > extent(ext_h))
			return 1'b1;
		if (int'(z_first) + int'(layers) > extent(ext_d))
			return 1'b1;
		return 1'b0;
	endfunction

	// Works out what one accepted voxel byte should produce and moves the
	// scan position on.
	function automatic void extract_active(voxel_t v);
		int unsigned half = int'(side_len) / 2;
		int unsigned xs   = (int'(ctr_x) >= half) ? int'(ctr_x) - half : 0;
		int unsigned ys   = (int'(ctr_y) >= half) ? int'(ctr_y) - half : 0;
		int unsigned zs   = int'(z_first);
		result_t     hit  = '0;
		if (window_fault(xs, ys)) begin
			// Only the first byte of the volume (or the first after the window
			// went bad) reports the error; the rest of the volume is silent.
			if (!error_given) begin
				hit.err = 1'b1;
				active_hits = {active_hits, hit};
				error_given = 1'b1;
			end
		end else if (v == VOXEL_ACTIVE && !error_given
				&& scan_x >= xs && scan_x < xs + int'(side_len)
				&& scan_y >= ys && scan_y < ys + int'(side_len)
				&& scan_z >= zs && scan_z < zs + int'(layers)) begin
			hit.lz  = local_t'(scan_z - zs);
			hit.ly  = local_t'(scan_y - ys);
			hit.lx  = local_t'(scan_x - xs);
			hit.id  = next_id;
			next_id = next_id + 1'b1;
			active_hits = {active_hits, hit};
		end
		if (step_scan(scan_x, scan_y, scan_z)) begin
			next_id     = '0;
			error_given = 1'b0;
		end
	endfunction

	function automatic void apply_reg(cfg_idx_t idx, cfg_data_t d);
		case (idx)
			REG_VOL_WIDTH:     ext_w    = ext_reg_t'(d);
			REG_VOL_HEIGHT:    ext_h    = ext_reg_t'(d);
			REG_VOL_DEPTH:     ext_d    = ext_reg_t'(d);
			REG_CENTER_X:      ctr_x    = crd_reg_t'(d);
			REG_CENTER_Y:      ctr_y    = crd_reg_t'(d);
			REG_START_Z:       z_first  = crd_reg_t'(d);
			REG_WINDOW_LENGTH: side_len = ext_reg_t'(d);
			REG_WINDOW_HEIGHT: layers   = ext_reg_t'(d);
			default: ;
		endcase
	endfunction

	// Number of bytes that bring the scan back to the origin under the
	// current settings; anything past the search bound counts as too far.
	function automatic int unsigned voxels_to_origin();
		int unsigned x = scan_x;
		int unsigned y = scan_y;
		int unsigned z = scan_z;
		int unsigned n = 0;
		if (x == 0 && y == 0 && z == 0)
			return 0;
		do begin
			n++;
		end while (!step_scan(x, y, z) && n <= ALIGN_MAX);
		return n;
	endfunction

	// Register writes and voxel transactions are followed at the clock edge
	// at which the block takes them. The two never share an edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (voxel_valid && voxel_ready)
				extract_active(voxel_value);
		end
	end

	// ------------------------------------------------------------------------
	// Voxel driver
	// ------------------------------------------------------------------------

	// Once valid is up it stays up, with the same byte, until the transaction
	// completes. A fresh byte is offered only when the idle draw allows it.
	always @(posedge clk) begin
		bit offer;
		if (arst_n) begin
			if (voxel_valid && voxel_ready)
				void'(voxel_backlog.pop_front());
			if (voxel_valid && !voxel_ready)
				offer = 1'b1;
			else
				offer = voxel_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct;
			voxel_valid <= offer;
			if (offer)
				voxel_value <= voxel_backlog[0];
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver and checker
	// ------------------------------------------------------------------------

	// Ready is dropped at random, and for a long stretch whenever the stimulus
	// asks for one, so that the output stage fills and the voxel side stalls.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		result_ready <= arst_n && hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
	end

	task automatic flag_mismatch(string what);
		if (mismatches < REPORT_LIMIT)
			$display("tb_top: mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (active_hits.size() == 0) begin
				flag_mismatch("result transaction with nothing expected");
			end else begin
				want = active_hits.pop_front();
				if (local_z !== want.lz)
					flag_mismatch($sformatf("local_z %0d, expected %0d", local_z, want.lz));
				if (local_y !== want.ly)
					flag_mismatch($sformatf("local_y %0d, expected %0d", local_y, want.ly));
				if (local_x !== want.lx)
					flag_mismatch($sformatf("local_x %0d, expected %0d", local_x, want.lx));
				if (active_id !== want.id)
					flag_mismatch($sformatf("active_id %0d, expected %0d", active_id, want.id));
				if (window_error !== want.err)
					flag_mismatch($sformatf("window_error %0b, expected %0b",
						window_error, want.err));
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: timed out with %0d results outstanding", active_hits.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic feed(int unsigned n, int unsigned one_pct);
		repeat (n) begin
			if ($urandom_range(99) < one_pct)
				voxel_backlog = {voxel_backlog, VOXEL_ACTIVE};
			else
				voxel_backlog = {voxel_backlog, voxel_t'($urandom_range(0, 255))};
		end
	endtask

	// Waits until every byte has been taken and every result has come back,
	// then lets the pipeline settle, since the last bytes may cause nothing.
	task automatic wait_idle();
		while (voxel_backlog.size() != 0 || voxel_valid)
			@(posedge clk);
		while (active_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
	endtask

	// Writes all eight registers on consecutive cycles. It returns on a
	// falling edge, by which time the shadow copy has taken the last write.
	task automatic load_window(input cfg_data_t w, h, d, cx, cy, sz, wl, wh);
		write_reg(REG_VOL_WIDTH, w);
		write_reg(REG_VOL_HEIGHT, h);
		write_reg(REG_VOL_DEPTH, d);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_START_Z, sz);
		write_reg(REG_WINDOW_LENGTH, wl);
		write_reg(REG_WINDOW_HEIGHT, wh);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Runs the scan on to the start of a volume, unless that is too far off.
	task automatic align_volume();
		int unsigned n;
		n = voxels_to_origin();
		if (n <= ALIGN_MAX)
			feed(n, 50);
	endtask

	// Small volumes with a window that mostly fits; now and then a window that
	// is broken in one particular way, or a depth past the largest volume.
	task automatic random_window();
		int unsigned w  = $urandom_range(1, 8);
		int unsigned h  = $urandom_range(1, 8);
		int unsigned d  = $urandom_range(1, 6);
		int unsigned wl, wh, xs, ys, cx, cy, sz;
		wl = $urandom_range(1, (w < h) ? w : h);
		xs = $urandom_range(0, w - wl);
		ys = $urandom_range(0, h - wl);
		cx = xs + wl / 2;
		cy = ys + wl / 2;
		wh = $urandom_range(1, d);
		sz = $urandom_range(0, d - wh);
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(0, 7))
				0: wl = 0;
				1: wh = 0;
				2: wl = 2047;
				3: wh = 2047;
				4: begin
					wl = $urandom_range(2, 8);
					cx = $urandom_range(0, wl / 2 - 1);
				end
				5: sz = d;
				6: begin
					case ($urandom_range(0, 2))
						0: w = 0;
						1: h = 0;
						default: d = 0;
					endcase
				end
				default: d = $urandom_range(1025, 2047);
			endcase
		end
		load_window(cfg_data_t'(w), cfg_data_t'(h), cfg_data_t'(d), cfg_data_t'(cx),
			cfg_data_t'(cy), cfg_data_t'(sz), cfg_data_t'(wl), cfg_data_t'(wh));
	endtask

	initial begin
		int unsigned phase;
		int unsigned random_fed;
		int unsigned vol;
		int unsigned n;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Settings straight out of reset: a full-size volume and a window that
		// covers it, so active bytes at the origin come out with their own
		// position and ids counting up. Extremes of the byte are included.
		voxel_backlog = {voxel_backlog, 8'd1, 8'd0, 8'd255, 8'd1, 8'd254, 8'd1};
		wait_idle();

		// Oversized extents with the window pushed to the far corners. The
		// centre along y is below half the side, so this reports an error once.
		// The centre along x is written with the spare top bit set.
		load_window(11'd2047, 11'd1, 11'd2047, 11'h7FF, 11'd0, 11'd1023, 11'd2, 11'd1);
		feed(3, 100);
		wait_idle();

		// The same corner window now fits, but the volume has already had its
		// error result, so it stays silent until the volume ends.
		load_window(11'd2047, 11'd2047, 11'd2047, 11'd1023, 11'd1, 11'd1023, 11'd2, 11'd1);
		feed(3, 100);
		wait_idle();

		// Zero width: every window is in error and x steps as if one voxel wide,
		// so each two-byte volume gives exactly one error result.
		load_window(11'd0, 11'd2, 11'd1, 11'd0, 11'd0, 11'd0, 11'd1, 11'd1);
		align_volume();
		feed(4, 50);
		wait_idle();

		// A window covering a whole small volume of active bytes while the
		// receiver holds off for a long stretch: the output stage fills and
		// the voxel side must stall without losing or reordering anything.
		load_window(11'd4, 11'd4, 11'd2, 11'd2, 11'd2, 11'd0, 11'd4, 11'd2);
		align_volume();
		hold_req++;
		feed(32, 100);
		wait_idle();

		// Random phases. Each one loads new settings, starts on a volume
		// boundary when it is near, sends one to three volumes' worth of bytes, at
		// most PHASE_ITEMS, then waits for the last result before the next register
		// writes. The bytes that line the scan up count towards the total as well.
		phase      = 0;
		random_fed = 0;
		while (random_fed < RANDOM_ITEMS) begin
			random_window();
			tx_idle_pct  = TX_IDLE[phase % 4];
			rx_stall_pct = RX_STALL[phase % 4];
			n = voxels_to_origin();
			if (n <= ALIGN_MAX) begin
				feed(n, 50);
				random_fed += n;
			end
			vol = ((ext_w == '0) ? 1 : extent(ext_w)) * ((ext_h == '0) ? 1 : extent(ext_h))
				* ((ext_d == '0) ? 1 : extent(ext_d));
			n = vol * $urandom_range(1, 3);
			if (n > PHASE_ITEMS || n == 0)
				n = PHASE_ITEMS;
			feed(n, 60);
			random_fed += n;
			wait_idle();
			phase++;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (active_hits.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", active_hits.size()));
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule : tb_top
